>>> src/assert_macros.svh
// Assertion helpers for the node table RTL.
// ASSERT_RST: checked at each rising edge, off while reset is held.
// ASSERT_ALWAYS: checked at each rising edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/mtbl_pkg.sv
package mtbl_pkg;

    localparam int NODES_DEF = 64;

    localparam logic [31:0] LIMIT_RST    = 32'd30000;
    localparam logic [7:0]  ST_ONLINE    = 8'd1;
    localparam logic [7:0]  ST_OFFLINE   = 8'd0;
    localparam logic [7:0]  TYPE_UNKNOWN = 8'd0;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_OFFLINE = 3'd2,
        CMD_UPDATE  = 3'd3,
        CMD_SWEEP   = 3'd4,
        CMD_LOOKUP  = 3'd5,
        CMD_READ    = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_FULL      = 2'd1,
        RC_NOT_FOUND = 2'd2,
        RC_BEYOND    = 2'd3
    } t_code;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic [47:0]        mac;
        logic [7:0]         status;
        logic [7:0]         dtype;
        logic [7:0]         layer;
        logic signed [7:0]  rssi;
        logic [23:0]        fw;
        logic [31:0]        seen_ms;
    } t_entry;

    typedef struct packed {
        logic [2:0]         command;
        logic [47:0]        mac;
        logic [31:0]        now;
        logic [7:0]         dtype;
        logic [7:0]         status;
        logic [7:0]         layer;
        logic signed [7:0]  rssi;
        logic [23:0]        fw;
        logic [5:0]         index;
    } t_req;

    typedef struct packed {
        t_code              code;
        logic [6:0]         count;
        logic [5:0]         hit;
        logic [6:0]         swept;
        t_entry             ent;
    } t_res;

endpackage

>>> src/mtbl_ifs.sv
interface mtbl_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [47:0]        node_mac;
    logic [31:0]        now_ms;
    logic [7:0]         device_type_in;
    logic [7:0]         status_in;
    logic [7:0]         mesh_layer_in;
    logic signed [7:0]  rssi_in;
    logic [23:0]        firmware_in;
    logic [5:0]         entry_index;

    modport source (
        output valid, command, node_mac, now_ms, device_type_in, status_in,
               mesh_layer_in, rssi_in, firmware_in, entry_index,
        input  ready
    );
    modport sink (
        input  valid, command, node_mac, now_ms, device_type_in, status_in,
               mesh_layer_in, rssi_in, firmware_in, entry_index,
        output ready
    );
endinterface

interface mtbl_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_code;
    logic [6:0]         node_count;
    logic [5:0]         hit_index;
    logic [6:0]         swept_count;
    logic [47:0]        mac_out;
    logic [7:0]         status_out;
    logic [7:0]         device_type_out;
    logic [7:0]         mesh_layer_out;
    logic signed [7:0]  rssi_out;
    logic [23:0]        firmware_out;
    logic [31:0]        last_seen_out;

    modport source (
        output valid, result_code, node_count, hit_index, swept_count, mac_out,
               status_out, device_type_out, mesh_layer_out, rssi_out,
               firmware_out, last_seen_out,
        input  ready
    );
    modport sink (
        input  valid, result_code, node_count, hit_index, swept_count, mac_out,
               status_out, device_type_out, mesh_layer_out, rssi_out,
               firmware_out, last_seen_out,
        output ready
    );
endinterface

>>> src/mac_keyed_node_table_with_aging.sv
// Channel   Dir  Handshake      Contents
// i_req     in   valid/ready    command, MAC key, time, heartbeat data, index
// o_res     out  valid/ready    result code, counts, hit index, entry fields
// i_cfg_*   in   write enable   timeout limit in ms
//
// One entry per cycle through a registered read port: a scan stops at a hit;
// a miss, sweep or remove walks every entry up to count; a read by index, an
// index beyond count or an unused command skips the scan.
// i_req.ready is high only while idle; a finished result waits in the output
// register while the next request runs, which then holds until it drains.
// Synchronous reset empties the table and restores the timeout limit.
module mac_keyed_node_table_with_aging
    import mtbl_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtbl_req_if.sink    i_req,
    mtbl_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    `include "assert_macros.svh"

    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    t_entry          r_mem [NODES];
    t_entry          r_rdata;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [31:0]     r_limit, n_limit;
    logic            r_ovld,  n_ovld;
    t_req            r_req,   n_req;
    logic [CW-1:0]   r_ptr,   n_ptr;
    logic [IW-1:0]   r_hit,   n_hit;
    logic [CW-1:0]   r_swept, n_swept;
    t_code           r_code,  n_code;
    logic            r_rep,   n_rep;
    t_entry          r_ent,   n_ent;
    t_res            r_out,   n_out;

    logic            w_we;
    logic [IW-1:0]   w_waddr;
    logic [IW-1:0]   w_raddr;
    t_entry          w_wdata;
    t_entry          w_mod;
    logic [CW-1:0]   w_ptr_inc;
    logic            w_inrange;
    logic            w_match;
    logic            w_aged;
    logic [31:0]     w_age;
    t_cmd            w_cmd;
    t_cmd            w_in_cmd;

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign w_cmd     = t_cmd'(r_req.command);
    assign w_in_cmd  = t_cmd'(i_req.command);
    assign w_ptr_inc = r_ptr + CW'(1);
    assign w_inrange = r_ptr < r_count;
    assign w_match   = r_rdata.mac == r_req.mac;
    assign w_age     = r_req.now - r_rdata.seen_ms;
    assign w_aged    = w_age > r_limit;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_limit = r_limit;
        n_ovld  = r_ovld && !o_res.ready;
        n_req   = r_req;
        n_ptr   = r_ptr;
        n_hit   = r_hit;
        n_swept = r_swept;
        n_code  = r_code;
        n_rep   = r_rep;
        n_ent   = r_ent;
        n_out   = r_out;
        w_we    = 1'b0;
        w_waddr = IW'(r_ptr);
        w_wdata = r_rdata;
        w_raddr = IW'(w_ptr_inc);
        w_mod   = r_rdata;
        i_req.ready = 1'b0;

        if (i_cfg_we) begin
            n_limit = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                w_raddr     = IW'(0);
                if (i_req.valid) begin
                    n_req.command = i_req.command;
                    n_req.mac     = i_req.node_mac;
                    n_req.now     = i_req.now_ms;
                    n_req.dtype   = i_req.device_type_in;
                    n_req.status  = i_req.status_in;
                    n_req.layer   = i_req.mesh_layer_in;
                    n_req.rssi    = i_req.rssi_in;
                    n_req.fw      = i_req.firmware_in;
                    n_req.index   = i_req.entry_index;
                    n_ptr   = '0;
                    n_hit   = '0;
                    n_swept = '0;
                    n_rep   = 1'b0;
                    n_code  = RC_OK;
                    case (w_in_cmd)
                        CMD_READ: begin
                            w_raddr = IW'(i_req.entry_index);
                            n_hit   = IW'(i_req.entry_index);
                            if (32'(i_req.entry_index) >= 32'(r_count)) begin
                                n_code  = RC_BEYOND;
                                n_hit   = '0;
                                n_state = S_PUSH;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        CMD_ADD, CMD_REMOVE, CMD_OFFLINE, CMD_UPDATE,
                        CMD_SWEEP, CMD_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_PUSH;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (!w_inrange) begin
                    // scan ran off the end: append (or report full), finish sweep, or miss
                    n_state = S_PUSH;
                    case (w_cmd)
                        CMD_ADD: begin
                            if (r_count == CW'(NODES)) begin
                                n_code = RC_FULL;
                            end else begin
                                w_mod.mac     = r_req.mac;
                                w_mod.status  = ST_ONLINE;
                                w_mod.dtype   = TYPE_UNKNOWN;
                                w_mod.layer   = '0;
                                w_mod.rssi    = '0;
                                w_mod.fw      = '0;
                                w_mod.seen_ms = r_req.now;
                                w_we    = 1'b1;
                                w_waddr = IW'(r_count);
                                w_wdata = w_mod;
                                n_ent   = w_mod;
                                n_rep   = 1'b1;
                                n_hit   = IW'(r_count);
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_SWEEP: begin
                            n_code = RC_OK;
                        end
                        default: begin
                            n_code = RC_NOT_FOUND;
                        end
                    endcase
                end else if (w_cmd == CMD_SWEEP) begin
                    if (r_rdata.status == ST_ONLINE && w_aged) begin
                        w_mod.status = ST_OFFLINE;
                        w_we    = 1'b1;
                        w_wdata = w_mod;
                        n_swept = r_swept + CW'(1);
                    end
                    n_ptr = w_ptr_inc;
                end else if (w_match) begin
                    n_hit   = IW'(r_ptr);
                    n_rep   = 1'b1;
                    n_state = S_PUSH;
                    case (w_cmd)
                        CMD_ADD: begin
                            w_mod.status  = ST_ONLINE;
                            w_mod.seen_ms = r_req.now;
                            w_we = 1'b1;
                        end
                        CMD_REMOVE: begin
                            // report the entry as it was, then close the gap
                            n_ptr   = w_ptr_inc;
                            n_state = S_SHIFT;
                        end
                        CMD_OFFLINE: begin
                            w_mod.status = ST_OFFLINE;
                            w_we = 1'b1;
                        end
                        CMD_UPDATE: begin
                            w_mod.dtype   = r_req.dtype;
                            w_mod.status  = r_req.status;
                            w_mod.layer   = r_req.layer;
                            w_mod.rssi    = r_req.rssi;
                            w_mod.fw      = r_req.fw;
                            w_mod.seen_ms = r_req.now;
                            w_we = 1'b1;
                        end
                        default: begin
                            n_rep = 1'b1;
                        end
                    endcase
                    w_wdata = w_mod;
                    n_ent   = w_mod;
                end else begin
                    n_ptr = w_ptr_inc;
                end
            end

            S_SHIFT: begin
                if (w_inrange) begin
                    // move entry down by one
                    w_we    = 1'b1;
                    w_waddr = IW'(r_ptr - CW'(1));
                    n_ptr   = w_ptr_inc;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_PUSH;
                end
            end

            S_READ: begin
                n_ent   = r_rdata;
                n_rep   = 1'b1;
                n_state = S_PUSH;
            end

            S_PUSH: begin
                if (!r_ovld || o_res.ready) begin
                    n_out.code  = r_code;
                    n_out.count = 7'(r_count);
                    n_out.hit   = 6'(r_hit);
                    n_out.swept = 7'(r_swept);
                    n_out.ent   = r_rep ? r_ent : '0;
                    n_ovld      = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_limit <= LIMIT_RST;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_limit <= n_limit;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_ptr   <= n_ptr;
        r_hit   <= n_hit;
        r_swept <= n_swept;
        r_code  <= n_code;
        r_rep   <= n_rep;
        r_ent   <= n_ent;
        r_out   <= n_out;
    end

    assign o_res.valid           = r_ovld;
    assign o_res.result_code     = r_out.code;
    assign o_res.node_count      = r_out.count;
    assign o_res.hit_index       = r_out.hit;
    assign o_res.swept_count     = r_out.swept;
    assign o_res.mac_out         = r_out.ent.mac;
    assign o_res.status_out      = r_out.ent.status;
    assign o_res.device_type_out = r_out.ent.dtype;
    assign o_res.mesh_layer_out  = r_out.ent.layer;
    assign o_res.rssi_out        = r_out.ent.rssi;
    assign o_res.firmware_out    = r_out.ent.fw;
    assign o_res.last_seen_out   = r_out.ent.seen_ms;

    `ASSERT_RST(a_count_max, i_clk, i_rst_n, r_count <= CW'(NODES), "count beyond table size")
    `ASSERT_RST(a_accept_leaves_idle, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> (r_state != S_IDLE), "accepted request left the sequencer idle")
    `ASSERT_RST(a_swept_le_count, i_clk, i_rst_n, (r_state != S_IDLE) |-> (r_swept <= r_count), "sweep counted more entries than present")
    `ASSERT_RST(a_count_step, i_clk, i_rst_n, $past(i_rst_n) |-> (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1) || r_count + CW'(1) == $past(r_count)), "count moved by more than one")

endmodule
